// ===== hdl/mecr_pkg.sv =====
package mecr_pkg;

	// Default build limits.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int MAX_RADIUS_DEF = 7;

	// Width used for position and size compares; covers the largest build limit.
	localparam int CMPW = 13;

	// Fixed field widths.
	localparam int GREEN_W = 8;
	localparam int PROD_W  = 16;
	localparam int COORD_W = 10;
	localparam int RESP_W  = 25;
	localparam int RAD_W   = 3;
	localparam int SIZE_W  = 11;

	// Configuration register indexes.
	localparam logic [1:0] CFG_RADIUS = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	// Register reset values.
	localparam logic [RAD_W-1:0]  RADIUS_RST = 3'd3;
	localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd480;

	typedef struct packed {
		logic [GREEN_W-1:0] green_value;
		logic               frame_start;
	} pixel_t;

	typedef struct packed {
		logic [COORD_W-1:0] centre_column;
		logic [COORD_W-1:0] centre_row;
		logic [RESP_W-1:0]  response_doubled;
	} result_t;

	// Gradient products of one column.
	typedef struct packed {
		logic [PROD_W-1:0]        xx;
		logic signed [PROD_W:0]   xy;
		logic [PROD_W-1:0]        yy;
	} prod_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PIX,
		S_ROW,
		S_WR,
		S_COL,
		S_ABS,
		S_MUL,
		S_DISC,
		S_SQRT,
		S_OUT
	} state_t;

endpackage

// ===== hdl/mecr_ram.sv =====
module mecr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/min_eigen_corner_response.sv =====
// Shi-Tomasi corner response over a raster stream of green samples.
// The pixel channel (pixel_valid/pixel_ready/pixel) takes one sample per
// transfer; frame_start marks pixel (0,0). The result channel
// (result_valid/result_ready/result) gives the centre position and twice
// the smaller structure tensor eigenvalue for each interior centre.
// The configuration port (cfg_write/cfg_index/cfg_data) sets radius, width
// and height; write it only while no pixel is in work.
// The block works on one pixel at a time. A pixel with no row sum only passes
// the pixel state. A pixel that updates the row sum store adds 2R+1 row sum
// steps and a store write, and one that completes a centre adds 2R+1 store
// reads, the absolute value, multiply and discriminant states, 26 square root
// steps (two bits per cycle with the default radius limit) and the output
// state: the row sum steps, store reads and serial square root set the pace.
// The result register lets the next pixel enter while a result waits; a
// new result waits in its last state until the receiver takes the old one.
// Reset restores the default registers and clears positions, gradient
// history and product history. The line stores need no clearing pass.
module min_eigen_corner_response #(
	parameter int MAX_WIDTH  = mecr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mecr_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_RADIUS = mecr_pkg::MAX_RADIUS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [1:0]                  cfg_index,
	input  logic [mecr_pkg::SIZE_W-1:0] cfg_data,
	input  logic                        pixel_valid,
	output logic                        pixel_ready,
	input  mecr_pkg::pixel_t            pixel,
	output logic                        result_valid,
	input  logic                        result_ready,
	output mecr_pkg::result_t           result
);

	localparam int CMPW     = mecr_pkg::CMPW;
	localparam int PROD_W   = mecr_pkg::PROD_W;
	localparam int GW       = mecr_pkg::GREEN_W;
	localparam int SPAN     = 2 * MAX_RADIUS + 1;
	localparam int KW       = $clog2(SPAN);
	localparam int ROW_W    = PROD_W + KW;
	localparam int COL_W    = ROW_W + KW;
	localparam int RSW      = 3 * ROW_W + 1;
	localparam int AW       = $clog2(SPAN * MAX_WIDTH);
	localparam int PW       = $clog2(MAX_WIDTH);
	localparam int CW       = $clog2(MAX_WIDTH + 1);
	localparam int YW       = $clog2(MAX_HEIGHT);
	localparam int LW       = $clog2(MAX_HEIGHT + 1);
	localparam int DW       = 2 * COL_W + 4;
	localparam int RTW      = COL_W + 2;
	localparam int QW       = COL_W + 5;
	localparam int SQ_STEPS = COL_W + 2;
	localparam int SW       = $clog2(SQ_STEPS + 1);
	localparam int EXW      = RTW + mecr_pkg::RESP_W;

	mecr_pkg::state_t state_q, state_d;

	// Configuration and position state.
	logic [mecr_pkg::RAD_W-1:0]  radius_q;
	logic [mecr_pkg::SIZE_W-1:0] width_q, height_q;
	logic [CW-1:0]               col_q;
	logic [LW-1:0]               line_q;
	logic [KW-1:0]               lslot_q;
	logic [GW-1:0]               rec0_q, rec1_q, rec2_q;
	mecr_pkg::prod_t             shift_q [SPAN];

	// Per-pixel work registers.
	logic [PW-1:0]            px_q;
	logic [YW-1:0]            py_q;
	logic [KW-1:0]            slot_q, rd_slot_q, k_q;
	logic [GW-1:0]            g_q;
	logic [ROW_W-1:0]         rxx_q, ryy_q;
	logic signed [ROW_W:0]    rxy_q;
	logic [KW:0]              iss_q;
	logic                     rd_vld_q;
	logic [COL_W-1:0]         a_q, c_q;
	logic signed [COL_W:0]    b_q;
	logic [COL_W-1:0]         diff_q, bm_q;
	logic [COL_W:0]           sum_q;
	logic [2*COL_W-1:0]       dd_q, bb_q;
	logic [DW-1:0]            dsh_q;
	logic [QW-1:0]            rem_q;
	logic [RTW-1:0]           root_q;
	logic [SW-1:0]            sq_q;
	logic                     out_valid_q;
	mecr_pkg::result_t        out_q;

	// Effective sizes after saturation.
	logic [CMPW-1:0] wd, ht, r_eff, two_r;
	always_comb begin
		wd = (CMPW'(width_q) > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : CMPW'(width_q);
		ht = (CMPW'(height_q) > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT) : CMPW'(height_q);
		r_eff = (CMPW'(radius_q) > CMPW'(MAX_RADIUS)) ? CMPW'(MAX_RADIUS)
			: CMPW'(radius_q);
		two_r = r_eff << 1;
	end

	// Position of the incoming pixel.
	logic [CMPW-1:0] pos_x, pos_y;
	logic [KW-1:0]   pos_slot;
	always_comb begin
		pos_x = pixel.frame_start ? '0 : CMPW'(col_q);
		pos_y = pixel.frame_start ? '0 : CMPW'(line_q);
		pos_slot = pixel.frame_start ? '0 : lslot_q;
		if (pos_x >= wd) begin
			pos_x = '0;
			pos_y = pos_y + 1'b1;
			pos_slot = (pos_slot == KW'(SPAN - 1)) ? '0 : pos_slot + 1'b1;
		end
		if (pos_y >= ht) begin
			pos_y = '0;
			pos_slot = '0;
		end
	end

	logic in_xfer;
	assign pixel_ready = (state_q == mecr_pkg::S_IDLE);
	assign in_xfer = pixel_valid && pixel_ready;

	// Previous line store.
	logic [GW-1:0] above;
	mecr_ram #(.WIDTH(GW), .DEPTH(MAX_WIDTH)) u_line (
		.clk  (clk),
		.we   (state_q == mecr_pkg::S_PIX),
		.waddr(px_q),
		.wdata(g_q),
		.re   (in_xfer),
		.raddr(pos_x[PW-1:0]),
		.rdata(above)
	);

	// Row sum store, one line of per-column sums per slot.
	logic [CMPW-1:0] cx, cy;
	logic [AW-1:0]   waddr_rs, raddr_rs;
	logic [RSW-1:0]  rdata_rs;
	logic            col_issue;
	assign cx = CMPW'(px_q) - 1'b1 - r_eff;
	assign cy = CMPW'(py_q) - r_eff;
	assign waddr_rs = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(cx);
	assign raddr_rs = AW'(rd_slot_q) * AW'(MAX_WIDTH) + AW'(cx);
	assign col_issue = (state_q == mecr_pkg::S_COL) && (CMPW'(iss_q) <= two_r);

	mecr_ram #(.WIDTH(RSW), .DEPTH(SPAN * MAX_WIDTH)) u_rows (
		.clk  (clk),
		.we   (state_q == mecr_pkg::S_WR),
		.waddr(waddr_rs),
		.wdata({rxx_q, rxy_q, ryy_q}),
		.re   (col_issue),
		.raddr(raddr_rs),
		.rdata(rdata_rs)
	);

	// Gradients and decisions of the current pixel.
	logic signed [GW:0] ix, iy;
	logic grad_ok, row_ok, centre_ok, k_last, col_done;
	assign ix = $signed({1'b0, g_q}) - $signed({1'b0, rec1_q});
	assign iy = $signed({1'b0, rec0_q}) - $signed({1'b0, rec2_q});
	assign grad_ok = (px_q >= PW'(2)) && (py_q != '0);
	assign row_ok = grad_ok && (CMPW'(px_q) >= two_r + CMPW'(2));
	assign centre_ok = (CMPW'(py_q) >= two_r + 1'b1) && (CMPW'(py_q) + CMPW'(2) <= ht);
	assign k_last = (CMPW'(k_q) == two_r);
	assign col_done = (CMPW'(iss_q) > two_r) && !rd_vld_q;

	// Square root step, two radicand bits per cycle.
	logic [QW-1:0] rem_sh, trial;
	logic          take;
	assign rem_sh = {rem_q[QW-3:0], dsh_q[DW-1 -: 2]};
	assign trial = QW'({root_q, 2'b01});
	assign take = (rem_sh >= trial);

	// Final response with saturation.
	logic [RTW-1:0] resp;
	logic [EXW-1:0] resp_ext;
	assign resp = RTW'(sum_q) - root_q;
	assign resp_ext = EXW'(resp);

	logic out_free;
	assign out_free = !out_valid_q || result_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mecr_pkg::S_IDLE: if (in_xfer) state_d = mecr_pkg::S_PIX;
			mecr_pkg::S_PIX:  state_d = row_ok ? mecr_pkg::S_ROW : mecr_pkg::S_IDLE;
			mecr_pkg::S_ROW:  if (k_last) state_d = mecr_pkg::S_WR;
			mecr_pkg::S_WR:   state_d = centre_ok ? mecr_pkg::S_COL : mecr_pkg::S_IDLE;
			mecr_pkg::S_COL:  if (col_done) state_d = mecr_pkg::S_ABS;
			mecr_pkg::S_ABS:  state_d = mecr_pkg::S_MUL;
			mecr_pkg::S_MUL:  state_d = mecr_pkg::S_DISC;
			mecr_pkg::S_DISC: state_d = mecr_pkg::S_SQRT;
			mecr_pkg::S_SQRT: if (sq_q == SW'(SQ_STEPS - 1)) state_d = mecr_pkg::S_OUT;
			mecr_pkg::S_OUT:  if (out_free) state_d = mecr_pkg::S_IDLE;
			default:          state_d = mecr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mecr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: registers, positions, gradient and product history, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= mecr_pkg::RADIUS_RST;
			width_q <= mecr_pkg::WIDTH_RST;
			height_q <= mecr_pkg::HEIGHT_RST;
			col_q <= '0;
			line_q <= '0;
			lslot_q <= '0;
			rec0_q <= '0;
			rec1_q <= '0;
			rec2_q <= '0;
			for (int i = 0; i < SPAN; i++) begin
				shift_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					mecr_pkg::CFG_RADIUS: radius_q <= cfg_data[mecr_pkg::RAD_W-1:0];
					mecr_pkg::CFG_WIDTH:  width_q <= cfg_data;
					mecr_pkg::CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_xfer) begin
				col_q <= CW'(pos_x + 1'b1);
				line_q <= LW'(pos_y);
				lslot_q <= pos_slot;
			end
			if (state_q == mecr_pkg::S_PIX) begin
				if (grad_ok) begin
					for (int i = SPAN - 1; i > 0; i--) begin
						shift_q[i] <= shift_q[i-1];
					end
					shift_q[0].xx <= PROD_W'(ix * ix);
					shift_q[0].xy <= (PROD_W+1)'(ix * iy);
					shift_q[0].yy <= PROD_W'(iy * iy);
				end
				rec1_q <= rec0_q;
				rec0_q <= g_q;
				rec2_q <= above;
			end
			if (state_q == mecr_pkg::S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath work registers.
	always_ff @(posedge clk) begin
		case (state_q)
			mecr_pkg::S_IDLE: begin
				px_q <= pos_x[PW-1:0];
				py_q <= pos_y[YW-1:0];
				slot_q <= pos_slot;
				g_q <= pixel.green_value;
				k_q <= '0;
				rxx_q <= '0;
				rxy_q <= '0;
				ryy_q <= '0;
			end
			mecr_pkg::S_ROW: begin
				rxx_q <= rxx_q + ROW_W'(shift_q[k_q].xx);
				rxy_q <= rxy_q + (ROW_W+1)'(shift_q[k_q].xy);
				ryy_q <= ryy_q + ROW_W'(shift_q[k_q].yy);
				k_q <= k_q + 1'b1;
			end
			mecr_pkg::S_WR: begin
				// First slot of the window: current slot minus 2R, modulo the span.
				if ((KW+1)'(slot_q) + (KW+1)'(SPAN) - (KW+1)'(two_r) >= (KW+1)'(SPAN)) begin
					rd_slot_q <= KW'((KW+1)'(slot_q) - (KW+1)'(two_r));
				end else begin
					rd_slot_q <= KW'((KW+1)'(slot_q) + (KW+1)'(SPAN) - (KW+1)'(two_r));
				end
				iss_q <= '0;
				rd_vld_q <= 1'b0;
				a_q <= '0;
				b_q <= '0;
				c_q <= '0;
			end
			mecr_pkg::S_COL: begin
				if (col_issue) begin
					rd_slot_q <= (rd_slot_q == KW'(SPAN - 1)) ? '0 : rd_slot_q + 1'b1;
					iss_q <= iss_q + 1'b1;
				end
				rd_vld_q <= col_issue;
				if (rd_vld_q) begin
					a_q <= a_q + COL_W'(rdata_rs[RSW-1 -: ROW_W]);
					b_q <= b_q + (COL_W+1)'($signed(rdata_rs[ROW_W +: ROW_W+1]));
					c_q <= c_q + COL_W'(rdata_rs[ROW_W-1:0]);
				end
			end
			mecr_pkg::S_ABS: begin
				diff_q <= (a_q >= c_q) ? a_q - c_q : c_q - a_q;
				bm_q <= COL_W'(b_q[COL_W] ? -b_q : b_q);
				sum_q <= (COL_W+1)'(a_q) + (COL_W+1)'(c_q);
			end
			mecr_pkg::S_MUL: begin
				dd_q <= diff_q * diff_q;
				bb_q <= bm_q * bm_q;
			end
			mecr_pkg::S_DISC: begin
				dsh_q <= DW'(dd_q) + (DW'(bb_q) << 2);
				rem_q <= '0;
				root_q <= '0;
				sq_q <= '0;
			end
			mecr_pkg::S_SQRT: begin
				if (take) begin
					rem_q <= rem_sh - trial;
					root_q <= {root_q[RTW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					root_q <= {root_q[RTW-2:0], 1'b0};
				end
				dsh_q <= dsh_q << 2;
				sq_q <= sq_q + 1'b1;
			end
			mecr_pkg::S_OUT: begin
				if (out_free) begin
					out_q.centre_column <= cx[mecr_pkg::COORD_W-1:0];
					out_q.centre_row <= cy[mecr_pkg::COORD_W-1:0];
					if (resp_ext > EXW'({mecr_pkg::RESP_W{1'b1}})) begin
						out_q.response_doubled <= '1;
					end else begin
						out_q.response_doubled <= resp_ext[mecr_pkg::RESP_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

`ifndef SYNTHESIS
	// The line slot always names a row of the store.
	assert property (@(posedge clk) disable iff (!arst_n) lslot_q < KW'(SPAN - 1) ||
		lslot_q == KW'(SPAN - 1))
	else $error("line slot out of range");

	// A new result is only loaded from the output state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == mecr_pkg::S_OUT))
	else $error("result raised outside the output state");

	// No pixel is taken while the square root is being worked out.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mecr_pkg::S_SQRT |=> !$past(in_xfer))
	else $error("pixel taken during square root");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int LINE_MAX   = 1024;
	localparam int ROWS_MAX   = 1024;
	localparam int RAD_MAX    = 7;
	localparam int RING       = 2 * RAD_MAX + 1;
	localparam int ITEM_GOAL  = 1850;
	localparam int CYCLE_CAP  = 3000000;
	localparam int DRAIN_WAIT = 100;

	typedef struct {
		logic [mecr_pkg::GREEN_W-1:0] green;
		bit                           first;
		bit                           typed;
		mecr_pkg::result_t            want;
	} table_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_write = 1'b0;
	logic [1:0]                  cfg_index = mecr_pkg::CFG_RADIUS;
	logic [mecr_pkg::SIZE_W-1:0] cfg_data = '0;
	logic                        pixel_valid = 1'b0;
	logic                        pixel_ready;
	mecr_pkg::pixel_t            pixel = '0;
	logic                        result_valid;
	logic                        result_ready = 1'b0;
	mecr_pkg::result_t           result;

	min_eigen_corner_response uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	always #5 clk = ~clk;

	// Predictor state: registers, line stores, gradient and product history.
	int unsigned     pr_radius, pr_width, pr_height;
	byte unsigned    above_line[LINE_MAX];
	longint          rsum_xx[RING][LINE_MAX];
	longint          rsum_xy[RING][LINE_MAX];
	longint          rsum_yy[RING][LINE_MAX];
	longint          prod_xx[RING], prod_xy[RING], prod_yy[RING];
	byte unsigned    left1, left2, above_left;
	int              col_pos, row_pos;

	mecr_pkg::result_t corner_queue[$];
	int              errors = 0;
	int              items_sent = 0;
	int              results_seen = 0;
	int              frames_sent = 0;
	int              cycles = 0;
	bit              calm = 1'b0;
	int              ready_hold = 0;

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Advance the corner predictor by one pixel; returns 1 if a centre completes.
	function automatic bit predict_corner(input mecr_pkg::pixel_t p,
			output mecr_pkg::result_t res);
		int r, wd, ht, px, py, xc, cy, slot, ix, iy;
		byte unsigned g, up;
		longint sxx, sxy, syy, a, b, c;
		longint unsigned diff, bm, disc, resp;
		bit hit;
		r = (pr_radius > RAD_MAX) ? RAD_MAX : pr_radius;
		wd = (pr_width > LINE_MAX) ? LINE_MAX : pr_width;
		ht = (pr_height > ROWS_MAX) ? ROWS_MAX : pr_height;
		g = p.green_value;
		hit = 1'b0;
		res = '0;
		if (p.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= wd) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= ht)
			row_pos = 0;
		px = col_pos;
		py = row_pos;
		up = above_line[px];
		above_line[px] = g;
		if (px >= 2 && py >= 1) begin
			ix = int'(g) - int'(left2);
			iy = int'(left1) - int'(above_left);
			for (int k = RING - 1; k > 0; k--) begin
				prod_xx[k] = prod_xx[k-1];
				prod_xy[k] = prod_xy[k-1];
				prod_yy[k] = prod_yy[k-1];
			end
			prod_xx[0] = ix * ix;
			prod_xy[0] = ix * iy;
			prod_yy[0] = iy * iy;
			xc = px - 1 - r;
			if (xc >= r + 1 && xc <= wd - r - 2) begin
				sxx = 0; sxy = 0; syy = 0;
				for (int k = 0; k <= 2 * r; k++) begin
					sxx += prod_xx[k];
					sxy += prod_xy[k];
					syy += prod_yy[k];
				end
				slot = py % RING;
				rsum_xx[slot][xc] = sxx;
				rsum_xy[slot][xc] = sxy;
				rsum_yy[slot][xc] = syy;
				cy = py - r;
				if (cy >= r + 1 && cy <= ht - r - 2) begin
					a = 0; b = 0; c = 0;
					for (int k = cy - r; k <= cy + r; k++) begin
						a += rsum_xx[k % RING][xc];
						b += rsum_xy[k % RING][xc];
						c += rsum_yy[k % RING][xc];
					end
					diff = (a >= c) ? a - c : c - a;
					bm = (b >= 0) ? b : -b;
					disc = diff * diff + 4 * bm * bm;
					resp = longint'(a + c) - floor_sqrt(disc);
					if (resp > (64'd1 << mecr_pkg::RESP_W) - 1)
						resp = (64'd1 << mecr_pkg::RESP_W) - 1;
					res.centre_column = xc[mecr_pkg::COORD_W-1:0];
					res.centre_row = cy[mecr_pkg::COORD_W-1:0];
					res.response_doubled = resp[mecr_pkg::RESP_W-1:0];
					hit = 1'b1;
				end
			end
		end
		left2 = left1;
		left1 = g;
		above_left = up;
		col_pos++;
		return hit;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (calm || roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Let the block drain before touching its registers.
	task automatic wait_idle();
		if (pixel_valid)
			pixel_valid <= 1'b0;
		while (corner_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[mecr_pkg::SIZE_W-1:0];
		case (idx)
			mecr_pkg::CFG_RADIUS: pr_radius = val & 7;
			mecr_pkg::CFG_WIDTH: pr_width = val & 11'h7FF;
			mecr_pkg::CFG_HEIGHT: pr_height = val & 11'h7FF;
			default: ;
		endcase
	endtask

	task automatic set_shape(input int unsigned r, input int unsigned w, input int unsigned h);
		wait_idle();
		write_reg(mecr_pkg::CFG_RADIUS, r);
		write_reg(mecr_pkg::CFG_WIDTH, w);
		write_reg(mecr_pkg::CFG_HEIGHT, h);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Offer one pixel and hold it until the transfer; optionally supply the expectation.
	task automatic send_pixel(input logic [mecr_pkg::GREEN_W-1:0] g, input bit fs,
			input bit typed, input mecr_pkg::result_t want);
		mecr_pkg::pixel_t p;
		mecr_pkg::result_t res;
		int gap;
		p.green_value = g;
		p.frame_start = fs;
		gap = pick_gap();
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (!pixel_ready)
			@(posedge clk);
		items_sent++;
		if (predict_corner(p, res))
			corner_queue.push_back(typed ? want : res);
	endtask

	function automatic logic [mecr_pkg::GREEN_W-1:0] pick_green(input int mode, input int x,
			input int y, input logic [mecr_pkg::GREEN_W-1:0] base);
		case (mode)
			0: return ((x + y) % 2) ? 8'hFF : 8'h00;
			1: return base;
			2: return $urandom_range(1) ? 8'hFF : 8'h00;
			3: return base + $urandom_range(15);
			default: return $urandom_range(255);
		endcase
	endfunction

	// Send one frame in raster order; extra pixels run past its end.
	task automatic send_frame(input int w, input int h, input int count, input bit stall_mid);
		int mode, x, y;
		logic [mecr_pkg::GREEN_W-1:0] base;
		mode = $urandom_range(6);
		base = $urandom_range(255);
		frames_sent++;
		for (int i = 0; i < count; i++) begin
			x = i % w;
			y = i / w;
			if (stall_mid && i == count / 2)
				wait_idle();
			send_pixel(pick_green(mode, x, y, base), i == 0, 1'b0, '0);
		end
	endtask

	// Result side: random stalls and in-order comparison.
	always @(posedge clk) begin
		cycles++;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (corner_queue.size() == 0) begin
				errors++;
				$display("unexpected result col %0d row %0d resp %0d", result.centre_column,
					result.centre_row, result.response_doubled);
			end else begin
				mecr_pkg::result_t want;
				want = corner_queue.pop_front();
				if (result.centre_column !== want.centre_column)
					report("centre_column", result.centre_column, want.centre_column);
				if (result.centre_row !== want.centre_row)
					report("centre_row", result.centre_row, want.centre_row);
				if (result.response_doubled !== want.response_doubled)
					report("response_doubled", result.response_doubled,
						want.response_doubled);
			end
		end
		if (ready_hold > 0) begin
			ready_hold--;
			result_ready <= 1'b0;
		end else if (!calm && $urandom_range(99) < 4) begin
			ready_hold = $urandom_range(40, 5);
			result_ready <= 1'b0;
		end else begin
			result_ready <= calm || ($urandom_range(99) < 75);
		end
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		table_row_t flat_frame[25];
		int r, w, h, count, roll;
		pr_radius = mecr_pkg::RADIUS_RST;
		pr_width = mecr_pkg::WIDTH_RST;
		pr_height = mecr_pkg::HEIGHT_RST;
		foreach (prod_xx[k]) begin
			prod_xx[k] = 0; prod_xy[k] = 0; prod_yy[k] = 0;
		end
		foreach (above_line[k])
			above_line[k] = 0;
		left1 = 0; left2 = 0; above_left = 0;
		col_pos = 0; row_pos = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// A flat 5x5 frame at full scale: the single centre has a zero response.
		for (int i = 0; i < 25; i++) begin
			flat_frame[i].green = 8'hFF;
			flat_frame[i].first = (i == 0);
			flat_frame[i].typed = (i == 19);
			flat_frame[i].want = '{10'd2, 10'd2, 25'd0};
		end
		set_shape(1, 5, 5);
		foreach (flat_frame[i])
			send_pixel(flat_frame[i].green, flat_frame[i].first, flat_frame[i].typed,
				flat_frame[i].want);

		// Size saturation, radius zero, and too-small frames.
		set_shape(0, 6, 6);
		send_frame(6, 6, 36, 1'b0);
		set_shape(2, 2047, 3);
		send_frame(1024, 3, 1030, 1'b0);
		set_shape(1, 4, 2047);
		send_frame(4, 1024, 40, 1'b0);
		set_shape(7, 3, 3);
		send_frame(3, 3, 9, 1'b0);

		// Random frames: mostly whole, some cut short or run past the end.
		while (items_sent < ITEM_GOAL) begin
			roll = $urandom_range(9);
			r = (roll < 2) ? RAD_MAX : (roll < 3) ? 0 : $urandom_range(4, 1);
			w = 2 * r + 3 + $urandom_range(6);
			h = 2 * r + 3 + $urandom_range(4);
			if (r > 0 && $urandom_range(9) == 0)
				w = $urandom_range(2 * r + 2, 3);
			set_shape(r, w, h);
			calm = ($urandom_range(4) == 0);
			roll = $urandom_range(9);
			count = (roll == 0) ? $urandom_range(w * h - 1, 1) :
				(roll == 1) ? w * h + $urandom_range(3 * w) : w * h;
			send_frame(w, h, count, frames_sent == 5);
			calm = 1'b0;
		end

		wait_idle();
		$display("covered %0d pixels in %0d frames, %0d corner results checked",
			items_sent, frames_sent, results_seen);
		$display("radius 0 to 7, widths and heights from 3 up to saturation");
		if (errors == 0 && corner_queue.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mecr_pkg.sv
hdl/mecr_ram.sv
hdl/min_eigen_corner_response.sv
bench/tb_top.sv
